@@ design/itbn_pkg.sv @@
`timescale 1ns / 1ps

package itbn_pkg;

    // Field widths
    localparam int NUMBER_W = 31;
    localparam int RADIX_W  = 5;
    localparam int DIGIT_W  = 4;
    localparam int CHAR_W   = 7;

    // Digit stack
    localparam int STACK_DEPTH = 32;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Divider: working word is the number padded to whole groups of quotient bits
    localparam int WORK_W         = 32;
    localparam int BITS_PER_CYCLE = 8;
    localparam int DIV_CYCLES     = WORK_W / BITS_PER_CYCLE;
    localparam int STEP_W         = $clog2(DIV_CYCLES);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Radix limits
    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    // Character codes
    localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0]  CHAR_NINE    = 7'h39;
    localparam logic [CHAR_W-1:0]  CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0]  CHAR_UPPER_F = 7'h46;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN    = 4'd10;

    typedef struct packed {
        logic [NUMBER_W-1:0] value;
        logic [RADIX_W-1:0]  base;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PUSH,
        S_READ,
        S_LOAD
    } t_back_state;

    // Map a digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = CHAR_UPPER_A + CHAR_W'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

@@ design/itbn_front.sv @@
`timescale 1ns / 1ps

module itbn_front (
    input  logic [itbn_pkg::NUMBER_W-1:0] i_number_in,
    input  logic [itbn_pkg::RADIX_W-1:0]  i_radix,
    output itbn_pkg::t_job                o_job
);

    // Clamp the base into the supported range
    always_comb begin
        o_job.value = i_number_in;
        if (i_radix < itbn_pkg::RADIX_MIN) begin
            o_job.base = itbn_pkg::RADIX_MIN;
        end else if (i_radix > itbn_pkg::RADIX_MAX) begin
            o_job.base = itbn_pkg::RADIX_MAX;
        end else begin
            o_job.base = i_radix;
        end
    end

endmodule

@@ design/itbn_queue.sv @@
`timescale 1ns / 1ps

module itbn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  itbn_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output itbn_pkg::t_job o_job
);

    itbn_pkg::t_job                  r_mem [itbn_pkg::QUEUE_DEPTH];
    logic [itbn_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [itbn_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [itbn_pkg::QCNT_W-1:0]     r_count;
    logic                            w_push;
    logic                            w_pop;

    assign o_full  = (r_count == itbn_pkg::QCNT_W'(itbn_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Store the incoming word
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                if (r_wr_ptr == itbn_pkg::QPTR_W'(itbn_pkg::QUEUE_DEPTH - 1)) begin
                    r_wr_ptr <= '0;
                end else begin
                    r_wr_ptr <= r_wr_ptr + 1'b1;
                end
            end
            if (w_pop) begin
                if (r_rd_ptr == itbn_pkg::QPTR_W'(itbn_pkg::QUEUE_DEPTH - 1)) begin
                    r_rd_ptr <= '0;
                end else begin
                    r_rd_ptr <= r_rd_ptr + 1'b1;
                end
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ design/itbn_back.sv @@
`timescale 1ns / 1ps

module itbn_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    input  itbn_pkg::t_job               i_job,
    output logic                         o_job_take,
    output logic                         o_valid,
    output logic [itbn_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                         o_last_digit,
    input  logic                         i_stall
);

    itbn_pkg::t_back_state               r_state, n_state;
    logic [itbn_pkg::WORK_W-1:0]         r_work, n_work;
    logic [itbn_pkg::RADIX_W-1:0]        r_base, n_base;
    logic [itbn_pkg::DIGIT_W-1:0]        r_rem, n_rem;
    logic [itbn_pkg::STEP_W-1:0]         r_step, n_step;
    logic [itbn_pkg::CNT_W-1:0]          r_count, n_count;
    logic                                r_out_valid, n_out_valid;
    logic [itbn_pkg::CHAR_W-1:0]         r_out_char, n_out_char;
    logic                                r_out_last, n_out_last;

    logic [itbn_pkg::DIGIT_W-1:0]        r_stack [itbn_pkg::STACK_DEPTH];
    logic [itbn_pkg::DIGIT_W-1:0]        r_rd_data;
    logic                                w_push;
    logic                                w_read;
    logic [itbn_pkg::CNT_W-1:0]          w_cnt_dec;

    // Divider step results
    logic [itbn_pkg::BITS_PER_CYCLE-1:0] w_top;
    logic [itbn_pkg::BITS_PER_CYCLE-1:0] w_quo;
    logic [itbn_pkg::DIGIT_W-1:0]        w_rem;

    assign w_cnt_dec    = r_count - 1'b1;
    assign o_valid      = r_out_valid;
    assign o_digit_char = r_out_char;
    assign o_last_digit = r_out_last;

    // Restoring division, one group of quotient bits per cycle
    always_comb begin
        logic [itbn_pkg::DIGIT_W-1:0] v_rem;
        logic [itbn_pkg::DIGIT_W:0]   v_trial;
        w_top = r_work[itbn_pkg::WORK_W-1 -: itbn_pkg::BITS_PER_CYCLE];
        v_rem = r_rem;
        w_quo = '0;
        for (int i = 0; i < itbn_pkg::BITS_PER_CYCLE; i++) begin
            v_trial = {v_rem, w_top[itbn_pkg::BITS_PER_CYCLE-1-i]};
            if (v_trial >= r_base) begin
                w_quo[itbn_pkg::BITS_PER_CYCLE-1-i] = 1'b1;
                v_rem = itbn_pkg::DIGIT_W'(v_trial - r_base);
            end else begin
                v_rem = v_trial[itbn_pkg::DIGIT_W-1:0];
            end
        end
        w_rem = v_rem;
    end

    // Sequence: take, divide and push each digit, then pop and emit
    always_comb begin
        n_state     = r_state;
        n_work      = r_work;
        n_base      = r_base;
        n_rem       = r_rem;
        n_step      = r_step;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_job_take  = 1'b0;
        w_push      = 1'b0;
        w_read      = 1'b0;
        case (r_state)
            itbn_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    o_job_take = 1'b1;
                    n_work     = itbn_pkg::WORK_W'(i_job.value);
                    n_base     = i_job.base;
                    n_rem      = '0;
                    n_step     = '0;
                    n_count    = '0;
                    // zero needs no division: push the single zero digit
                    if (i_job.value == '0) begin
                        n_state = itbn_pkg::S_PUSH;
                    end else begin
                        n_state = itbn_pkg::S_DIV;
                    end
                end
            end
            itbn_pkg::S_DIV: begin
                n_work = {r_work[itbn_pkg::WORK_W-itbn_pkg::BITS_PER_CYCLE-1:0], w_quo};
                n_rem  = w_rem;
                n_step = r_step + 1'b1;
                if (r_step == itbn_pkg::STEP_W'(itbn_pkg::DIV_CYCLES - 1)) begin
                    n_state = itbn_pkg::S_PUSH;
                end
            end
            itbn_pkg::S_PUSH: begin
                if (r_count < itbn_pkg::CNT_W'(itbn_pkg::STACK_DEPTH)) begin
                    w_push  = 1'b1;
                    n_count = r_count + 1'b1;
                end
                n_rem  = '0;
                n_step = '0;
                if (r_work == '0) begin
                    n_state = itbn_pkg::S_READ;
                end else begin
                    n_state = itbn_pkg::S_DIV;
                end
            end
            itbn_pkg::S_READ: begin
                w_read  = 1'b1;
                n_count = w_cnt_dec;
                n_state = itbn_pkg::S_LOAD;
            end
            itbn_pkg::S_LOAD: begin
                // hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_char  = itbn_pkg::digit_to_char(r_rd_data);
                    n_out_last  = (r_count == '0);
                    if (r_count == '0) begin
                        n_state = itbn_pkg::S_IDLE;
                    end else begin
                        n_state = itbn_pkg::S_READ;
                    end
                end
            end
            default: begin
                n_state = itbn_pkg::S_IDLE;
            end
        endcase
    end

    // Digit stack memory
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[r_count[itbn_pkg::PTR_W-1:0]] <= r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_read) begin
            r_rd_data <= r_stack[w_cnt_dec[itbn_pkg::PTR_W-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= itbn_pkg::S_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_work     <= n_work;
        r_base     <= n_base;
        r_rem      <= n_rem;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= itbn_pkg::CNT_W'(itbn_pkg::STACK_DEPTH))
        else $error("digit stack count beyond depth");

    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == itbn_pkg::S_DIV) |-> (itbn_pkg::RADIX_W'(r_rem) < r_base))
        else $error("partial remainder not below base");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == itbn_pkg::S_READ) |-> (r_count != '0))
        else $error("pop from empty digit stack");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == itbn_pkg::S_IDLE) |-> (r_count == '0))
        else $error("digit stack not drained between words");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_char >= itbn_pkg::CHAR_ZERO && r_out_char <= itbn_pkg::CHAR_NINE)
                      || (r_out_char >= itbn_pkg::CHAR_UPPER_A
                          && r_out_char <= itbn_pkg::CHAR_UPPER_F)))
        else $error("output character is not a digit");

endmodule

@@ design/integer_to_base_n_digits.sv @@
`timescale 1ns / 1ps

// Converts a 31-bit unsigned integer to its digit string in a base from 2 to 16
// (bases outside that range are clamped), emitting one ASCII word per digit,
// '0'-'9' then 'A'-'F', most significant digit first; o_last_digit marks the
// least significant digit, and zero gives the single digit '0'. A two-word queue
// sits behind the input, so up to two numbers can wait while one is converted.
// Conversion of one number runs in order: the divider, which resolves 8 quotient
// bits per cycle, yields each digit as a remainder, which is pushed onto the
// digit stack; the digits are then popped through the stack memory's registered
// read port into the output register, and a stalled output holds the pop. The
// worst case, base 2, gives 31 digits.
module integer_to_base_n_digits (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [itbn_pkg::NUMBER_W-1:0] i_number_in,
    input  logic [itbn_pkg::RADIX_W-1:0]  i_radix,
    output logic                         o_stall,
    output logic                         o_valid,
    output logic [itbn_pkg::CHAR_W-1:0]  o_digit_char,
    output logic                         o_last_digit,
    input  logic                         i_stall
);

    itbn_pkg::t_job w_front_job;
    itbn_pkg::t_job w_queue_job;
    logic           w_queue_valid;
    logic           w_queue_full;
    logic           w_take;

    assign o_stall = w_queue_full;

    // Clamp the base
    itbn_front u_front (
        .i_number_in (i_number_in),
        .i_radix     (i_radix),
        .o_job       (w_front_job)
    );

    // Buffer words between front and back
    itbn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_job   (w_front_job),
        .o_full  (w_queue_full),
        .i_pop   (w_take),
        .o_valid (w_queue_valid),
        .o_job   (w_queue_job)
    );

    // Divide, stack and emit digits
    itbn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (w_queue_valid),
        .i_job        (w_queue_job),
        .o_job_take   (w_take),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last_digit (o_last_digit),
        .i_stall      (i_stall)
    );

endmodule
